>>> design/bpg_pkg.sv
// Package for the battery percentage gauge: breakpoint table, clamp constants
// and the segment helper functions. Used by battery_percent_gauge; no dependencies.
package bpg_pkg;

    typedef logic [7:0] gauge_pt_t;
    typedef logic [3:0] seg_idx_t;
    typedef logic [10:0] scaled_t;

    localparam int GAUGE_POINTS = 11;
    localparam logic [9:0] GAUGE_FLOOR = 10'd761;
    localparam logic [9:0] GAUGE_OFFSET = 10'd760;
    localparam logic [9:0] GAUGE_CEIL = 10'd240;
    localparam logic [3:0] GAUGE_STEP = 4'd10;

    localparam gauge_pt_t GAUGE_TABLE [GAUGE_POINTS] = '{
        8'd0, 8'd109, 8'd136, 8'd141, 8'd143, 8'd152,
        8'd164, 8'd179, 8'd196, 8'd214, 8'd240
    };

    // Width of a segment that ends at breakpoint seg (seg is 1 to 10).
    function automatic gauge_pt_t seg_span(input seg_idx_t seg);
        gauge_pt_t hi;
        gauge_pt_t lo;
        hi = GAUGE_TABLE[seg];
        lo = (seg == 4'd0) ? GAUGE_TABLE[0] : GAUGE_TABLE[seg - 4'd1];
        return gauge_pt_t'(hi - lo);
    endfunction

    // Step threshold k times the span of a segment; the quotient of
    // ten times the offset into the segment is the count of thresholds met.
    function automatic scaled_t seg_threshold(input seg_idx_t seg, input logic [3:0] k);
        return scaled_t'(k) * scaled_t'(seg_span(seg));
    endfunction

endpackage

>>> design/battery_percent_gauge.sv
// Battery percentage gauge: four-stage pipeline from reading to level.
// Throughput is one request per cycle while the output is not stalled; the stages
// are clamp, segment search, threshold compare and sum.
// A stalled output holds every valid stage in place without loss.
// Reset (rst_n, asynchronous) clears only the stage valid bits; no other state.
// Depends on bpg_pkg.
module battery_percent_gauge (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [9:0] battery_reading,
    input  logic       status_pin_high,
    input  logic       status_pin_low,
    input  logic       mode,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] charge_state,
    output logic [9:0] level_value
);

    // Stage 1: clamped offset.
    logic                s1_vld_reg;
    logic [1:0]          s1_state_reg;
    logic                s1_mode_reg;
    logic [9:0]          s1_raw_reg;
    bpg_pkg::gauge_pt_t  s1_v_reg;
    bpg_pkg::gauge_pt_t  s1_v_next;

    // Stage 2: segment and offset into it.
    logic                s2_vld_reg;
    logic [1:0]          s2_state_reg;
    logic                s2_mode_reg;
    logic [9:0]          s2_raw_reg;
    bpg_pkg::seg_idx_t   s2_seg_reg;
    bpg_pkg::seg_idx_t   s2_seg_next;
    bpg_pkg::gauge_pt_t  s2_diff_reg;
    bpg_pkg::gauge_pt_t  s2_diff_next;

    // Stage 3: threshold hits.
    logic                s3_vld_reg;
    logic [1:0]          s3_state_reg;
    logic                s3_mode_reg;
    logic [9:0]          s3_raw_reg;
    bpg_pkg::seg_idx_t   s3_seg_reg;
    logic [9:0]          s3_ge_reg;
    logic [9:0]          s3_ge_next;

    // Output stage.
    logic                out_vld_reg;
    logic [1:0]          out_state_reg;
    logic [9:0]          out_level_reg;
    logic [9:0]          out_level_next;

    logic s1_load;
    logic s2_load;
    logic s3_load;
    logic out_load;

    assign out_load = !out_vld_reg || out_ready;
    assign s3_load  = !s3_vld_reg || out_load;
    assign s2_load  = !s2_vld_reg || s3_load;
    assign s1_load  = !s1_vld_reg || s2_load;
    assign in_ready = s1_load;

    always_comb
    begin
        logic [9:0] off;
        off = battery_reading - bpg_pkg::GAUGE_OFFSET;
        if (battery_reading < bpg_pkg::GAUGE_FLOOR)
        begin
            s1_v_next = 8'd1;
        end
        else if (off > bpg_pkg::GAUGE_CEIL)
        begin
            s1_v_next = bpg_pkg::gauge_pt_t'(bpg_pkg::GAUGE_CEIL);
        end
        else
        begin
            s1_v_next = off[7:0];
        end
    end

    // The table rises, so the segment is one plus the count of inner points
    // that the offset lies above.
    always_comb
    begin
        bpg_pkg::seg_idx_t seg;
        seg = 4'd1;
        for (int j = 1; j < bpg_pkg::GAUGE_POINTS - 1; j++)
        begin
            if (s1_v_reg > bpg_pkg::GAUGE_TABLE[j])
            begin
                seg = seg + 4'd1;
            end
        end
        s2_seg_next  = seg;
        s2_diff_next = bpg_pkg::gauge_pt_t'(s1_v_reg - bpg_pkg::GAUGE_TABLE[seg - 4'd1]);
    end

    always_comb
    begin
        bpg_pkg::scaled_t scaled;
        scaled = bpg_pkg::scaled_t'(s2_diff_reg) * bpg_pkg::scaled_t'(bpg_pkg::GAUGE_STEP);
        for (int k = 0; k < 10; k++)
        begin
            s3_ge_next[k] = scaled >= bpg_pkg::seg_threshold(s2_seg_reg, 4'(k + 1));
        end
    end

    always_comb
    begin
        logic [6:0] pct;
        pct = 7'(s3_seg_reg - 4'd1) * 7'(bpg_pkg::GAUGE_STEP);
        for (int k = 0; k < 10; k++)
        begin
            pct = pct + 7'(s3_ge_reg[k]);
        end
        out_level_next = s3_mode_reg ? s3_raw_reg : 10'(pct);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
            begin
                s1_vld_reg <= in_valid;
            end
            if (s2_load)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (s3_load)
            begin
                s3_vld_reg <= s2_vld_reg;
            end
            if (out_load)
            begin
                out_vld_reg <= s3_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            s1_state_reg <= {status_pin_high, status_pin_low};
            s1_mode_reg  <= mode;
            s1_raw_reg   <= battery_reading;
            s1_v_reg     <= s1_v_next;
        end
        if (s2_load && s1_vld_reg)
        begin
            s2_state_reg <= s1_state_reg;
            s2_mode_reg  <= s1_mode_reg;
            s2_raw_reg   <= s1_raw_reg;
            s2_seg_reg   <= s2_seg_next;
            s2_diff_reg  <= s2_diff_next;
        end
        if (s3_load && s2_vld_reg)
        begin
            s3_state_reg <= s2_state_reg;
            s3_mode_reg  <= s2_mode_reg;
            s3_raw_reg   <= s2_raw_reg;
            s3_seg_reg   <= s2_seg_reg;
            s3_ge_reg    <= s3_ge_next;
        end
        if (out_load && s3_vld_reg)
        begin
            out_state_reg <= s3_state_reg;
            out_level_reg <= out_level_next;
        end
    end

    assign out_valid    = out_vld_reg;
    assign charge_state = out_state_reg;
    assign level_value  = out_level_reg;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for battery_percent_gauge: directed corner requests,
// a long output hold-off, random traffic with idling, and a steady tail.
// Depends on the battery_percent_gauge RTL only; the level predictor is local.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        DISCHARGING = 2'd0,
        CHARGED     = 2'd1,
        CHARGING    = 2'd2,
        FAULT       = 2'd3
    } charge_code_t;

    localparam logic MODE_PERCENT = 1'b0;
    localparam logic MODE_RAW     = 1'b1;

    localparam int READ_FLOOR  = 761;
    localparam int READ_OFFSET = 760;
    localparam int OFFSET_CEIL = 240;
    localparam int LAST_POINT  = 10;
    localparam int PCT_STEP    = 10;
    localparam int BREAKPOINT [11] = '{0, 109, 136, 141, 143, 152, 164, 179, 196, 214, 240};

    localparam int RANDOM_ITEMS = 1340;
    localparam int TAIL_ITEMS   = 100;
    localparam int HOLD_CYCLES  = 80;
    localparam int SETTLE       = 12;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        charge_code_t state;
        logic [9:0]   level;
    } gauge_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [9:0] battery_reading = '0;
    logic       status_pin_high = 1'b0;
    logic       status_pin_low = 1'b0;
    logic       mode = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] charge_state;
    logic [9:0] level_value;

    gauge_result_t gauge_expected [$];
    int  mismatches = 0;
    int  cycle_count = 0;
    logic rx_random = 1'b0;
    logic hold_armed = 1'b0;
    logic rx_hold = 1'b0;
    int  rx_burst = 0;
    bit  tx_random = 1'b0;

    battery_percent_gauge DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .battery_reading (battery_reading),
        .status_pin_high (status_pin_high),
        .status_pin_low  (status_pin_low),
        .mode            (mode),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .charge_state    (charge_state),
        .level_value     (level_value)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("battery_percent_gauge verification failed");
            $finish;
        end
    end

    // Piecewise-linear percentage: clamp, locate the segment, interpolate.
    function automatic logic [9:0] gauge_level(input logic [9:0] reading);
        int v;
        int seg;
        int lo;
        int span;
        v = int'(reading);
        if (v < READ_FLOOR)
            v = READ_FLOOR;
        v = v - READ_OFFSET;
        if (v > OFFSET_CEIL)
            v = OFFSET_CEIL;
        seg = 1;
        while (seg < LAST_POINT && v > BREAKPOINT[seg])
            seg++;
        lo = BREAKPOINT[seg - 1];
        span = BREAKPOINT[seg] - lo;
        return 10'(PCT_STEP * (seg - 1) + (PCT_STEP * (v - lo)) / span);
    endfunction

    function automatic gauge_result_t gauge_predict(input logic [9:0] reading,
                                                    input logic hi, input logic lo,
                                                    input logic raw);
        gauge_result_t r;
        r.state = charge_code_t'({hi, lo});
        r.level = (raw == MODE_RAW) ? reading : gauge_level(reading);
        return r;
    endfunction

    // Output side: compare each accepted result, then pick the next ready.
    always @(posedge clk)
    begin
        gauge_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (gauge_expected.size() == 0)
            begin
                $error("unexpected result: charge_state %0d level_value %0d",
                       charge_state, level_value);
                mismatches++;
            end
            else
            begin
                want = gauge_expected.pop_front();
                if (charge_state !== want.state)
                begin
                    $error("charge_state expected %0d actual %0d", want.state, charge_state);
                    mismatches++;
                end
                if (level_value !== want.level)
                begin
                    $error("level_value expected %0d actual %0d", want.level, level_value);
                    mismatches++;
                end
            end
        end

        if (rx_hold)
            out_ready <= 1'b0;
        else if (!rx_random)
            out_ready <= 1'b1;
        else if (rx_burst > 0)
        begin
            out_ready <= 1'b0;
            rx_burst <= rx_burst - 1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            out_ready <= 1'b0;
            rx_burst <= $urandom_range(0, 4);
        end
        else
            out_ready <= 1'b1;
    end

    // Long hold-off on the output, counted here so the sender keeps pushing.
    initial
    begin : receiver_holdoff
        wait (hold_armed);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic idle_for(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Valid is left high after acceptance; the idle task lowers it.
    task automatic send_reading(input logic [9:0] reading, input logic hi,
                                input logic lo, input logic raw);
        in_valid <= 1'b1;
        battery_reading <= reading;
        status_pin_high <= hi;
        status_pin_low <= lo;
        mode <= raw;
        do
            @(posedge clk);
        while (!in_ready);
        gauge_expected.push_back(gauge_predict(reading, hi, lo, raw));
        if (tx_random && $urandom_range(0, 5) == 0)
            idle_for($urandom_range(1, 5));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (gauge_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic test_directed();
        int i;
        send_reading(10'd0, 1'b0, 1'b0, MODE_PERCENT);
        send_reading(10'd760, 1'b0, 1'b1, MODE_PERCENT);
        send_reading(10'd761, 1'b1, 1'b0, MODE_PERCENT);
        send_reading(10'd762, 1'b1, 1'b1, MODE_PERCENT);
        send_reading(10'd999, 1'b0, 1'b0, MODE_PERCENT);
        send_reading(10'd1000, 1'b0, 1'b1, MODE_PERCENT);
        send_reading(10'd1023, 1'b1, 1'b0, MODE_PERCENT);
        // Each breakpoint exactly, taken from the segment that ends there.
        for (i = 1; i <= LAST_POINT; i++)
            send_reading(10'(READ_OFFSET + BREAKPOINT[i]), i[1], i[0], MODE_PERCENT);
        send_reading(10'd0, 1'b1, 1'b1, MODE_RAW);
        send_reading(10'd1023, 1'b0, 1'b0, MODE_RAW);
        send_reading(10'h155, 1'b0, 1'b1, MODE_RAW);
        send_reading(10'h2AA, 1'b1, 1'b0, MODE_RAW);
        send_reading(10'd870, 1'b1, 1'b1, MODE_PERCENT);
        wait_drained();
    endtask

    task automatic test_holdoff();
        int i;
        hold_armed <= 1'b1;
        for (i = 0; i < 40; i++)
            send_reading(10'($urandom_range(740, 1023)), 1'($urandom), 1'($urandom),
                         1'($urandom));
        // Sender pauses here until every outstanding request has completed.
        wait_drained();
    endtask

    task automatic random_batch(input int count);
        int i;
        logic [9:0] reading;
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) < 7)
                reading = 10'($urandom_range(755, 1023));
            else
                reading = 10'($urandom);
            send_reading(reading, 1'($urandom), 1'($urandom),
                         ($urandom_range(0, 3) == 0) ? MODE_RAW : MODE_PERCENT);
        end
    endtask

    task automatic test_random();
        tx_random = 1'b1;
        rx_random <= 1'b1;
        random_batch(RANDOM_ITEMS);
        tx_random = 1'b0;
        rx_random <= 1'b0;
        wait_drained();
    endtask

    task automatic test_steady();
        random_batch(TAIL_ITEMS);
        wait_drained();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_holdoff();
        test_random();
        test_steady();
        if (gauge_expected.size() != 0)
        begin
            $error("%0d expected results never arrived", gauge_expected.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("battery_percent_gauge verification clean");
        else
            $display("battery_percent_gauge verification failed");
        $finish;
    end

endmodule

>>> files.f
design/bpg_pkg.sv
design/battery_percent_gauge.sv
tb/testbench.sv
